// ===== rtl/cbb_pkg.sv =====
// shared constants, types and arctangent table for the compass bearing pipeline
package cbb_pkg;

    // coordinate and angle formats
    localparam int COORD_WIDTH     = 24;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_STAGES   = 18;
    localparam int RUN_STAGES      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    // difference vector and normalization
    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int NORM_MSB = 30;
    localparam int SH_W     = 5;
    localparam int POS_W    = $clog2(DIFF_W);
    localparam int NORM_W   = ((DIFF_W > 31) ? DIFF_W : 31) + 1;
    localparam int CW_W     = NORM_W + 3;

    // angle accumulator, a full turn is 2^ANG_W
    localparam int                ANG_W     = 32;
    localparam logic [ANG_W-1:0]  HALF_TURN = {1'b1, {(ANG_W-1){1'b0}}};

    // bearing output
    localparam int               BEAR_W     = 15;
    localparam int               FULL_SCALE = 360 << ANGLE_FRAC_BITS;
    localparam int               RES_W      = $clog2(FULL_SCALE + 1);
    localparam logic [RES_W-1:0] FULL_VAL   = RES_W'(FULL_SCALE);
    localparam int               PROD_W     = ANG_W + RES_W;
    localparam int               EXT_W      = (RES_W > BEAR_W) ? RES_W : BEAR_W;

    // start edge to result transfer edge
    localparam int LATENCY = RUN_STAGES + 6;

    typedef struct packed {
        logic valid;
        logic same;
    } t_ctl;

    typedef struct packed {
        logic signed [CW_W-1:0] u;
        logic signed [CW_W-1:0] v;
        logic [ANG_W-1:0]       angle;
    } t_vec;

    // round(atan(2^-i) * 2^32 / (2*pi))
    function automatic logic [ANG_W-1:0] atan_turn(input int idx);
        case (idx)
            0:       return 32'd536870912;
            1:       return 32'd316933406;
            2:       return 32'd167458907;
            3:       return 32'd85004756;
            4:       return 32'd42667331;
            5:       return 32'd21354465;
            6:       return 32'd10679838;
            7:       return 32'd5340245;
            8:       return 32'd2670163;
            9:       return 32'd1335087;
            10:      return 32'd667544;
            11:      return 32'd333772;
            12:      return 32'd166886;
            13:      return 32'd83443;
            14:      return 32'd41722;
            15:      return 32'd20861;
            16:      return 32'd10430;
            17:      return 32'd5215;
            18:      return 32'd2608;
            19:      return 32'd1304;
            20:      return 32'd652;
            21:      return 32'd326;
            22:      return 32'd163;
            23:      return 32'd81;
            24:      return 32'd41;
            25:      return 32'd20;
            26:      return 32'd10;
            27:      return 32'd5;
            28:      return 32'd3;
            29:      return 32'd1;
            30:      return 32'd1;
            default: return '0;
        endcase
    endfunction

endpackage

// ===== rtl/cbb_prep.sv =====
// front end: difference vector, normalization shift and half-turn pre-rotation
module cbb_prep (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic signed [cbb_pkg::COORD_WIDTH-1:0] i_from_x,
    input  logic signed [cbb_pkg::COORD_WIDTH-1:0] i_from_y,
    input  logic signed [cbb_pkg::COORD_WIDTH-1:0] i_to_x,
    input  logic signed [cbb_pkg::COORD_WIDTH-1:0] i_to_y,
    output cbb_pkg::t_ctl                        o_ctl,
    output cbb_pkg::t_vec                        o_vec
);
    import cbb_pkg::*;

    // stage 1 registers
    logic                     r1_vld;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy;
    logic signed [DIFF_W-1:0] n1_dx, n1_dy;

    // stage 2 registers
    logic                     r2_vld;
    logic signed [DIFF_W-1:0] r2_dx, r2_dy;
    logic [DIFF_W-1:0]        r2_mag;
    logic [DIFF_W-1:0]        n2_mag;
    logic [DIFF_W-1:0]        mag_x, mag_y;

    // stage 3 registers
    t_ctl                     r3_ctl;
    logic signed [DIFF_W-1:0] r3_dx, r3_dy;
    logic [SH_W-1:0]          r3_sh;
    logic [SH_W-1:0]          n3_sh;
    logic [POS_W-1:0]         msb_pos;

    // stage 4 registers
    t_ctl                     r4_ctl;
    t_vec                     r4_vec;
    t_vec                     n4_vec;
    logic signed [NORM_W-1:0] ext_x, ext_y, sh_x, sh_y;

    // difference of the two points
    always_comb begin
        n1_dx = DIFF_W'(i_to_x) - DIFF_W'(i_from_x);
        n1_dy = DIFF_W'(i_to_y) - DIFF_W'(i_from_y);
    end

    // magnitudes share their leading one with the larger one, so an or serves as max
    always_comb begin
        mag_x  = r1_dx[DIFF_W-1] ? DIFF_W'(-r1_dx) : DIFF_W'(r1_dx);
        mag_y  = r1_dy[DIFF_W-1] ? DIFF_W'(-r1_dy) : DIFF_W'(r1_dy);
        n2_mag = mag_x | mag_y;
    end

    // leading one search and shift that lifts the magnitude to bit NORM_MSB
    always_comb begin
        msb_pos = '0;
        for (int b = 0; b < DIFF_W; b++) begin
            if (r2_mag[b]) begin
                msb_pos = POS_W'(b);
            end
        end
        if (int'(msb_pos) >= NORM_MSB) begin
            n3_sh = '0;
        end else begin
            n3_sh = SH_W'(NORM_MSB - int'(msb_pos));
        end
    end

    // normalize and rotate by a half turn when the north component is negative
    always_comb begin
        ext_x = NORM_W'(r3_dx);
        ext_y = NORM_W'(r3_dy);
        sh_x  = ext_x <<< r3_sh;
        sh_y  = ext_y <<< r3_sh;
        if (sh_y[NORM_W-1]) begin
            n4_vec.u     = -CW_W'(sh_y);
            n4_vec.v     = -CW_W'(sh_x);
            n4_vec.angle = HALF_TURN;
        end else begin
            n4_vec.u     = CW_W'(sh_y);
            n4_vec.v     = CW_W'(sh_x);
            n4_vec.angle = '0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld       <= 1'b0;
            r2_vld       <= 1'b0;
            r3_ctl.valid <= 1'b0;
            r4_ctl.valid <= 1'b0;
        end else begin
            r1_vld       <= i_load;
            r2_vld       <= r1_vld;
            r3_ctl.valid <= r2_vld;
            r4_ctl.valid <= r3_ctl.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r1_dx       <= n1_dx;
        r1_dy       <= n1_dy;
        r2_dx       <= r1_dx;
        r2_dy       <= r1_dy;
        r2_mag      <= n2_mag;
        r3_dx       <= r2_dx;
        r3_dy       <= r2_dy;
        r3_sh       <= n3_sh;
        r3_ctl.same <= (r2_mag == '0);
        r4_ctl.same <= r3_ctl.same;
        r4_vec      <= n4_vec;
    end

    assign o_ctl = r4_ctl;
    assign o_vec = r4_vec;

endmodule

// ===== rtl/cbb_cordic.sv =====
// cordic vectoring pipeline, one micro-rotation per register stage
module cbb_cordic (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cbb_pkg::t_ctl i_ctl,
    input  cbb_pkg::t_vec i_vec,
    output cbb_pkg::t_ctl o_ctl,
    output cbb_pkg::t_vec o_vec
);
    import cbb_pkg::*;

    t_ctl w_ctl [RUN_STAGES+1];
    t_vec w_vec [RUN_STAGES+1];
    t_ctl r_ctl [RUN_STAGES];
    t_vec r_vec [RUN_STAGES];
    t_vec n_vec [RUN_STAGES];

    assign w_ctl[0] = i_ctl;
    assign w_vec[0] = i_vec;

    for (genvar g = 0; g < RUN_STAGES; g++) begin : g_stage
        logic signed [CW_W-1:0] us, vs;

        // rotate toward the u axis, direction set by the sign of v
        always_comb begin
            us = w_vec[g].u >>> g;
            vs = w_vec[g].v >>> g;
            if (!w_vec[g].v[CW_W-1]) begin
                n_vec[g].u     = w_vec[g].u + vs;
                n_vec[g].v     = w_vec[g].v - us;
                n_vec[g].angle = w_vec[g].angle + atan_turn(g);
            end else begin
                n_vec[g].u     = w_vec[g].u - vs;
                n_vec[g].v     = w_vec[g].v + us;
                n_vec[g].angle = w_vec[g].angle - atan_turn(g);
            end
        end

        // stage valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g].valid <= 1'b0;
            end else begin
                r_ctl[g].valid <= w_ctl[g].valid;
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            r_ctl[g].same <= w_ctl[g].same;
            r_vec[g]      <= n_vec[g];
        end

        assign w_ctl[g+1] = r_ctl[g];
        assign w_vec[g+1] = r_vec[g];
    end

    assign o_ctl = w_ctl[RUN_STAGES];
    assign o_vec = w_vec[RUN_STAGES];

endmodule

// ===== rtl/cbb_scale.sv =====
// turn fraction to degrees: constant multiply, round half up, wrap 360 to 0
module cbb_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cbb_pkg::t_ctl              i_ctl,
    input  logic [cbb_pkg::ANG_W-1:0]  i_angle,
    output logic                       o_strobe,
    output logic [cbb_pkg::BEAR_W-1:0] o_bearing_deg,
    output logic                       o_same_point
);
    import cbb_pkg::*;

    t_ctl              r_ctl;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;

    logic              r_strobe;
    logic [BEAR_W-1:0] r_bearing;
    logic [BEAR_W-1:0] n_bearing;
    logic              r_same;

    logic [PROD_W-1:0] rsum;
    logic [RES_W-1:0]  rounded;
    logic [EXT_W-1:0]  ext;

    // angle times 1/64 degree steps per turn
    assign n_prod = PROD_W'(i_angle) * PROD_W'(FULL_VAL);

    // round, wrap a full circle, force zero for coincident points
    always_comb begin
        rsum    = r_prod + PROD_W'(HALF_TURN);
        rounded = rsum[PROD_W-1:ANG_W];
        if (r_ctl.same || (rounded >= FULL_VAL)) begin
            ext = '0;
        end else begin
            ext = EXT_W'(rounded);
        end
        n_bearing = ext[BEAR_W-1:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
            r_strobe    <= r_ctl.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_ctl.same <= i_ctl.same;
        r_prod     <= n_prod;
        r_same     <= r_ctl.same;
        r_bearing  <= n_bearing;
    end

    assign o_strobe      = r_strobe;
    assign o_bearing_deg = r_bearing;
    assign o_same_point  = r_same;

endmodule

// ===== rtl/compass_bearing_between_points.sv =====
// top level of the compass bearing pipeline
//
// Bearing from point A to point B, clockwise from north in 1/64 degree steps
// (0 to 23039). A new pair of points is taken on every clock edge where start is
// high and busy is low; busy is low at all times outside reset, so one pair per
// cycle is sustained. The result is shown for one cycle with o_strobe high after
// passing through four front-end stages (difference, magnitude, normalization shift,
// pre-rotation), 18 CORDIC stages, and a multiply and a rounding stage. The receiver
// must take each result in its strobe cycle, since there is no way to hold results
// off. Coincident points give bearing 0 with o_same_point set.
module compass_bearing_between_points (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [cbb_pkg::COORD_WIDTH-1:0] i_from_x,
    input  logic signed [cbb_pkg::COORD_WIDTH-1:0] i_from_y,
    input  logic signed [cbb_pkg::COORD_WIDTH-1:0] i_to_x,
    input  logic signed [cbb_pkg::COORD_WIDTH-1:0] i_to_y,
    output logic                                   o_strobe,
    output logic [cbb_pkg::BEAR_W-1:0]             o_bearing_deg,
    output logic                                   o_same_point
);
    import cbb_pkg::*;

    logic load;
    t_ctl prep_ctl, cordic_ctl;
    t_vec prep_vec, cordic_vec;

    // the pipeline never stalls, so transfers are refused only in reset
    assign busy = ~i_rst_n;
    assign load = start & ~busy;

    // front end
    cbb_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_from_x (i_from_x),
        .i_from_y (i_from_y),
        .i_to_x   (i_to_x),
        .i_to_y   (i_to_y),
        .o_ctl    (prep_ctl),
        .o_vec    (prep_vec)
    );

    // vectoring stages
    cbb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (prep_ctl),
        .i_vec   (prep_vec),
        .o_ctl   (cordic_ctl),
        .o_vec   (cordic_vec)
    );

    // conversion to degrees and output register
    cbb_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (cordic_ctl),
        .i_angle       (cordic_vec.angle),
        .o_strobe      (o_strobe),
        .o_bearing_deg (o_bearing_deg),
        .o_same_point  (o_same_point)
    );

endmodule

// ===== rtl/cbb_checker.sv =====
// port-level checks for the compass bearing pipeline and their bind
module cbb_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic signed [cbb_pkg::COORD_WIDTH-1:0] i_from_x,
    input logic signed [cbb_pkg::COORD_WIDTH-1:0] i_from_y,
    input logic signed [cbb_pkg::COORD_WIDTH-1:0] i_to_x,
    input logic signed [cbb_pkg::COORD_WIDTH-1:0] i_to_y,
    input logic                                   o_strobe,
    input logic [cbb_pkg::BEAR_W-1:0]             o_bearing_deg,
    input logic                                   o_same_point
);
    import cbb_pkg::*;

    // every transfer in gives a result after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("transfer in without result after pipeline latency");

    // no result without a transfer in at the matching edge
    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result without matching transfer in");

    // coincident flag follows the inputs of the matching transfer
    a_same_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_same_point ==
            $past((i_from_x == i_to_x) && (i_from_y == i_to_y), LATENCY)))
        else $error("same point flag does not match inputs");

    // bearing stays below a full circle and is zero for coincident points
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((EXT_W'(o_bearing_deg) < EXT_W'(FULL_VAL)) &&
            (!o_same_point || (o_bearing_deg == '0))))
        else $error("bearing out of range");

endmodule

bind compass_bearing_between_points cbb_checker u_cbb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_from_x      (i_from_x),
    .i_from_y      (i_from_y),
    .i_to_x        (i_to_x),
    .i_to_y        (i_to_y),
    .o_strobe      (o_strobe),
    .o_bearing_deg (o_bearing_deg),
    .o_same_point  (o_same_point)
);
